// ===== hdl/skl_pkg.sv =====
// Shared types and constants for the sorted key table lookup block.
package skl_pkg;

    // Default table depth
    localparam int TABLE_DEPTH_DEF = 1024;

    // Field types
    typedef logic [1:0]  command_t;
    typedef logic [9:0]  index_t;
    typedef logic [23:0] key_t;
    typedef logic [7:0]  etype_t;
    typedef logic [31:0] value_t;
    typedef logic [10:0] count_t;

    // Command codes
    localparam command_t CMD_WRITE  = 2'd0;
    localparam command_t CMD_LOOKUP = 2'd1;
    localparam command_t CMD_READ   = 2'd2;

    // Request payload
    typedef struct packed {
        command_t command;
        index_t   entry_index;
        key_t     search_key;
        etype_t   entry_type;
        value_t   entry_value;
    } req_t;

    // Result payload
    typedef struct packed {
        logic   found;
        index_t hit_index;
        etype_t hit_type;
        value_t hit_value;
    } rsp_t;

    // One table entry as stored in memory
    typedef struct packed {
        key_t   key;
        etype_t etype;
        value_t value;
    } entry_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_FETCH
    } state_t;

endpackage

// ===== hdl/sorted_key_table_lookup.sv =====
// Sorted key table: entry writes, binary-search lookup and index reads.
//
//  channel   | signals                          | dir | transfer
//  ----------+----------------------------------+-----+--------------------------
//  request   | start, busy, request             | in  | start & !busy
//  result    | done, result                     | out | done, one cycle, no stall
//  config    | cfg_valid, cfg_ready, entry_count| in  | cfg_valid & cfg_ready
//
// Write, unknown command and immediate misses: done follows in the cycle after the
// request is accepted. Index read: one registered memory read, then the registered
// result. Lookup: probes <= floor(log2(count)) + 1; the single memory read port
// gives one probe per cycle.
// Reset clears control and entry_count only; table contents are undefined until
// written. The result strobe cannot be stalled; busy holds off new requests.
module sorted_key_table_lookup #(
    parameter int TABLE_DEPTH = skl_pkg::TABLE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  skl_pkg::req_t   request,
    output logic            done,
    output skl_pkg::rsp_t   result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  skl_pkg::count_t entry_count
);

    localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CntW  = $clog2(TABLE_DEPTH + 1);

    // Control registers
    skl_pkg::state_t  state_reg, state_next;
    skl_pkg::count_t  count_reg;
    logic             done_reg, done_next;

    // Search payload registers
    logic [CntW-1:0]  lo_reg, lo_next;
    logic [CntW-1:0]  hi_reg, hi_next;
    logic [AddrW-1:0] mid_reg, mid_next;
    skl_pkg::key_t    key_reg, key_next;
    skl_pkg::rsp_t    result_reg, result_next;

    // Table memory
    skl_pkg::entry_t  entry_mem [TABLE_DEPTH];
    skl_pkg::entry_t  rd_data_reg;
    logic             rd_en, wr_en;
    logic [AddrW-1:0] rd_addr, wr_addr;
    skl_pkg::entry_t  wr_data;

    // Datapath helpers
    logic             accept;
    logic [CntW-1:0]  eff_count;
    logic             wr_in_range;
    logic             rd_in_range;
    logic             key_eq, key_gt;
    logic [CntW-1:0]  lo_adv, hi_adv;
    logic [CntW:0]    bound_sum;
    logic [AddrW-1:0] mid_adv;
    logic             range_open;

    assign busy      = (state_reg != skl_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    // Count clamped to the table depth
    always_comb
    begin
        if (32'(count_reg) > 32'(TABLE_DEPTH))
            eff_count = CntW'(TABLE_DEPTH);
        else
            eff_count = CntW'(count_reg);
    end

    assign wr_in_range = (32'(request.entry_index) < 32'(TABLE_DEPTH));
    assign rd_in_range = (32'(request.entry_index) < 32'(eff_count));

    // Probe compare and narrowed bounds
    assign key_eq     = (key_reg == rd_data_reg.key);
    assign key_gt     = (key_reg > rd_data_reg.key);
    assign lo_adv     = key_gt ? (CntW'(mid_reg) + CntW'(1)) : lo_reg;
    assign hi_adv     = key_gt ? hi_reg : CntW'(mid_reg);
    assign bound_sum  = {1'b0, lo_adv} + {1'b0, hi_adv};
    assign mid_adv    = AddrW'(bound_sum >> 1);
    assign range_open = (lo_adv < hi_adv);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.command == skl_pkg::CMD_LOOKUP && eff_count != '0)
                        state_next = skl_pkg::ST_PROBE;
                    else if (request.command == skl_pkg::CMD_READ && rd_in_range)
                        state_next = skl_pkg::ST_FETCH;
                end
            end
            skl_pkg::ST_PROBE:
            begin
                if (key_eq || !range_open)
                    state_next = skl_pkg::ST_IDLE;
            end
            skl_pkg::ST_FETCH:
                state_next = skl_pkg::ST_IDLE;
            default:
                state_next = skl_pkg::ST_IDLE;
        endcase
    end

    // Outputs, memory access and search bounds
    always_comb
    begin
        done_next   = 1'b0;
        result_next = result_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        key_next    = key_reg;
        rd_en       = 1'b0;
        rd_addr     = mid_reg;
        wr_en       = 1'b0;
        wr_addr     = AddrW'(request.entry_index);
        wr_data     = '{key: request.search_key, etype: request.entry_type,
                        value: request.entry_value};
        unique case (state_reg)
            skl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    key_next = request.search_key;
                    unique case (request.command)
                        skl_pkg::CMD_WRITE:
                        begin
                            done_next = 1'b1;
                            if (wr_in_range)
                            begin
                                wr_en       = 1'b1;
                                result_next = '{found: 1'b1,
                                                hit_index: request.entry_index,
                                                hit_type: request.entry_type,
                                                hit_value: request.entry_value};
                            end
                            else
                                result_next = '0;
                        end
                        skl_pkg::CMD_LOOKUP:
                        begin
                            if (eff_count == '0)
                            begin
                                done_next   = 1'b1;
                                result_next = '0;
                            end
                            else
                            begin
                                // first probe at the middle of [0, count)
                                lo_next  = '0;
                                hi_next  = eff_count;
                                mid_next = AddrW'(eff_count >> 1);
                                rd_en    = 1'b1;
                                rd_addr  = AddrW'(eff_count >> 1);
                            end
                        end
                        skl_pkg::CMD_READ:
                        begin
                            if (rd_in_range)
                            begin
                                mid_next = AddrW'(request.entry_index);
                                rd_en    = 1'b1;
                                rd_addr  = AddrW'(request.entry_index);
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '0;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                    endcase
                end
            end
            skl_pkg::ST_PROBE:
            begin
                if (key_eq)
                begin
                    done_next   = 1'b1;
                    result_next = '{found: 1'b1, hit_index: skl_pkg::index_t'(mid_reg),
                                    hit_type: rd_data_reg.etype,
                                    hit_value: rd_data_reg.value};
                end
                else
                begin
                    lo_next = lo_adv;
                    hi_next = hi_adv;
                    if (range_open)
                    begin
                        // next probe issued straight from the narrowed range
                        mid_next = mid_adv;
                        rd_en    = 1'b1;
                        rd_addr  = mid_adv;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                end
            end
            skl_pkg::ST_FETCH:
            begin
                done_next   = 1'b1;
                result_next = '{found: 1'b1, hit_index: skl_pkg::index_t'(mid_reg),
                                hit_type: rd_data_reg.etype,
                                hit_value: rd_data_reg.value};
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skl_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
                count_reg <= entry_count;
        end
    end

    // Search and result payload
    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        key_reg    <= key_next;
        result_reg <= result_next;
    end

    // Table memory: one write port, one registered read port.
    // Writes happen only for an accepted write command, which issues no read, so no overlap.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= entry_mem[rd_addr];
    end

endmodule
